>>> rtl/slrd_pkg.sv
// Shared types and constants for the SLIP receive ring deframer.
// No dependencies; imported by the controller, datapath and top level.
package slrd_pkg;

  localparam int unsigned BufDepthDef = 2048;
  localparam int unsigned CfgW        = 11;
  localparam logic [CfgW-1:0] MaxLenRst = 11'd1280;

  localparam logic [7:0] CH_END     = 8'o300;
  localparam logic [7:0] CH_ESC     = 8'o333;
  localparam logic [7:0] CH_ESC_END = 8'o334;
  localparam logic [7:0] CH_ESC_ESC = 8'o335;

  typedef enum logic [1:0] {
    MODE_NORMAL,
    MODE_ESCAPE,
    MODE_RUBBISH
  } rx_mode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_PREV_RD,
    ST_PREV_CK,
    ST_RD_BYTE,
    ST_RD_CODE,
    ST_REL,
    ST_SRCH_RD,
    ST_SRCH_CK,
    ST_EMIT
  } ctrl_state_e;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_LINE,
    DP_PREV_RD,
    DP_PREV_CK,
    DP_RD_START,
    DP_RD_BYTE,
    DP_RD_CODE,
    DP_DROP,
    DP_REL,
    DP_SRCH_CK,
    DP_EMIT
  } dp_op_e;

  typedef struct packed {
    logic is_read;
    logic have_frame;
    logic over_len;
    logic line_prev;
    logic esc_mid;
    logic nxt_is_end;
    logic srch_end;
    logic rdata_end;
    logic out_free;
  } dp_status_t;

endpackage

>>> rtl/slrd_ctrl.sv
// Controller state machine for the SLIP receive ring deframer.
// Depends on slrd_pkg; drives slrd_datapath through dp_op_e commands.
module slrd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  input  slrd_pkg::dp_status_t st_i,
  output slrd_pkg::dp_op_e    op_o
);
  import slrd_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (req_valid_i) state_d = ST_DISPATCH;
      ST_DISPATCH: begin
        if (!st_i.is_read) begin
          state_d = st_i.line_prev ? ST_PREV_RD : ST_EMIT;
        end else if (!st_i.have_frame) begin
          state_d = ST_EMIT;
        end else if (st_i.over_len) begin
          state_d = ST_REL;
        end else begin
          state_d = ST_RD_BYTE;
        end
      end
      ST_PREV_RD:  state_d = ST_PREV_CK;
      ST_PREV_CK:  state_d = ST_EMIT;
      ST_RD_BYTE: begin
        if (st_i.esc_mid) begin
          state_d = ST_RD_CODE;
        end else begin
          state_d = st_i.nxt_is_end ? ST_REL : ST_EMIT;
        end
      end
      ST_RD_CODE:  state_d = st_i.nxt_is_end ? ST_REL : ST_EMIT;
      ST_REL:      state_d = ST_SRCH_RD;
      ST_SRCH_RD:  state_d = st_i.srch_end ? ST_EMIT : ST_SRCH_CK;
      ST_SRCH_CK:  state_d = st_i.rdata_end ? ST_EMIT : ST_SRCH_RD;
      ST_EMIT:     if (st_i.out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    op_o        = DP_NOP;
    req_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) op_o = DP_LOAD;
      end
      ST_DISPATCH: begin
        if (!st_i.is_read) begin
          op_o = DP_LINE;
        end else if (!st_i.have_frame) begin
          op_o = DP_NOP;
        end else if (st_i.over_len) begin
          op_o = DP_DROP;
        end else begin
          op_o = DP_RD_START;
        end
      end
      ST_PREV_RD: op_o = DP_PREV_RD;
      ST_PREV_CK: op_o = DP_PREV_CK;
      ST_RD_BYTE: op_o = DP_RD_BYTE;
      ST_RD_CODE: op_o = DP_RD_CODE;
      ST_REL:     op_o = DP_REL;
      ST_SRCH_CK: op_o = DP_SRCH_CK;
      ST_EMIT:    if (st_i.out_free) op_o = DP_EMIT;
      default:    op_o = DP_NOP;
    endcase
  end

endmodule

>>> rtl/slrd_datapath.sv
// Datapath for the SLIP receive ring deframer: ring store, pointers, mode
// and result register. Depends on slrd_pkg; commanded by slrd_ctrl.
module slrd_datapath #(
  parameter int unsigned BufDepth = slrd_pkg::BufDepthDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  slrd_pkg::dp_op_e           op_i,
  output slrd_pkg::dp_status_t       st_o,
  input  logic                       in_op_i,
  input  logic [7:0]                 in_byte_i,
  input  logic                       cfg_we_i,
  input  logic [slrd_pkg::CfgW-1:0]  cfg_wdata_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [10:0]                out_data_o,
  output logic                       out_last_o
);
  import slrd_pkg::*;

  localparam int unsigned AW = (BufDepth > 1) ? $clog2(BufDepth) : 1;
  localparam logic [AW-1:0] PLast = AW'(BufDepth - 1);

  function automatic logic [AW-1:0] fwd(input logic [AW-1:0] p);
    return (p == PLast) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AW-1:0] back(input logic [AW-1:0] p);
    return (p == '0) ? PLast : p - 1'b1;
  endfunction

  logic [7:0]      mem [BufDepth];
  logic [7:0]      rdata_q;
  logic [AW-1:0]   raddr;
  logic            mem_we;

  logic [AW-1:0]   frame_start_q, ready_end_q, write_ptr_q, cursor_q, cur_q, srch_q;
  logic [CfgW-1:0] count_q, maxlen_q;
  rx_mode_e        mode_q;
  logic            op_q;
  logic [7:0]      byte_q;

  logic            res_done_q, res_valid_q, res_last_q, res_drop_q;
  logic [7:0]      res_byte_q;
  logic            mvalid_q, mlast_q;
  logic [10:0]     mdata_q;

  logic            have_frame, bad_esc, full, line_store, line_prev;
  logic [AW-1:0]   nxt;
  logic [7:0]      code_dec;

  assign have_frame = frame_start_q != ready_end_q;
  assign nxt        = fwd(write_ptr_q);
  assign bad_esc    = (mode_q == MODE_ESCAPE) && (byte_q != CH_ESC_END) &&
                      (byte_q != CH_ESC_ESC);
  assign full       = nxt == frame_start_q;
  assign line_store = (mode_q != MODE_RUBBISH) && !bad_esc && !full;
  assign line_prev  = line_store && (byte_q == CH_END) && (write_ptr_q != ready_end_q);
  assign mem_we     = (op_i == DP_LINE) && line_store;
  assign code_dec   = (rdata_q == CH_ESC_END) ? CH_END :
                      (rdata_q == CH_ESC_ESC) ? CH_ESC : rdata_q;

  always_comb begin
    st_o.is_read    = op_q;
    st_o.have_frame = have_frame;
    st_o.over_len   = count_q >= maxlen_q;
    st_o.line_prev  = line_prev;
    st_o.nxt_is_end = fwd(cursor_q) == ready_end_q;
    st_o.esc_mid    = (rdata_q == CH_ESC) && (fwd(cursor_q) != ready_end_q);
    st_o.srch_end   = srch_q == write_ptr_q;
    st_o.rdata_end  = rdata_q == CH_END;
    st_o.out_free   = !mvalid_q || out_ready_i;
  end

  always_comb begin
    case (op_i)
      DP_PREV_RD:  raddr = back(cur_q);
      DP_RD_START: raddr = cursor_q;
      DP_RD_BYTE:  raddr = fwd(cursor_q);
      default:     raddr = srch_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[write_ptr_q] <= byte_q;
    end
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      maxlen_q <= MaxLenRst;
    end else if (cfg_we_i) begin
      maxlen_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_start_q <= '0;
      ready_end_q   <= '0;
      write_ptr_q   <= '0;
      cursor_q      <= '0;
      count_q       <= '0;
      mode_q        <= MODE_NORMAL;
      mvalid_q      <= 1'b0;
    end else begin
      if (op_i == DP_EMIT) begin
        mvalid_q <= 1'b1;
      end else if (mvalid_q && out_ready_i) begin
        mvalid_q <= 1'b0;
      end
      case (op_i)
        DP_LINE: begin
          if (mode_q == MODE_RUBBISH) begin
            if (byte_q == CH_END) mode_q <= MODE_NORMAL;
          end else if (bad_esc || full) begin
            write_ptr_q <= have_frame ? fwd(ready_end_q) : ready_end_q;
            mode_q      <= MODE_RUBBISH;
          end else begin
            mode_q <= (byte_q == CH_ESC) ? MODE_ESCAPE : MODE_NORMAL;
            if ((byte_q == CH_END) && (write_ptr_q == ready_end_q)) begin
              write_ptr_q <= write_ptr_q;
            end else begin
              write_ptr_q <= nxt;
            end
          end
        end
        DP_PREV_CK: begin
          if (rdata_q == CH_END) begin
            write_ptr_q <= cur_q;
          end else if (!have_frame) begin
            ready_end_q <= cur_q;
            cursor_q    <= frame_start_q;
            count_q     <= '0;
          end
        end
        DP_RD_BYTE: begin
          cursor_q <= fwd(cursor_q);
          if (!st_o.esc_mid) count_q <= count_q + 1'b1;
        end
        DP_RD_CODE: begin
          cursor_q <= fwd(cursor_q);
          count_q  <= count_q + 1'b1;
        end
        DP_REL: begin
          frame_start_q <= fwd(ready_end_q);
          ready_end_q   <= fwd(ready_end_q);
          cursor_q      <= fwd(ready_end_q);
          count_q       <= '0;
        end
        DP_SRCH_CK: begin
          if (rdata_q == CH_END) ready_end_q <= srch_q;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (op_i)
      DP_LOAD: begin
        op_q        <= in_op_i;
        byte_q      <= in_byte_i;
        res_done_q  <= 1'b0;
        res_valid_q <= 1'b0;
        res_byte_q  <= '0;
        res_last_q  <= 1'b0;
        res_drop_q  <= 1'b0;
      end
      DP_LINE:    cur_q <= write_ptr_q;
      DP_PREV_CK: if (rdata_q != CH_END) res_done_q <= 1'b1;
      DP_RD_BYTE: begin
        if (!st_o.esc_mid) begin
          res_valid_q <= 1'b1;
          res_byte_q  <= rdata_q;
          res_last_q  <= st_o.nxt_is_end;
        end
      end
      DP_RD_CODE: begin
        res_valid_q <= 1'b1;
        res_byte_q  <= code_dec;
        res_last_q  <= st_o.nxt_is_end;
      end
      DP_DROP:    res_drop_q <= 1'b1;
      DP_REL:     srch_q <= fwd(ready_end_q);
      DP_SRCH_CK: srch_q <= fwd(srch_q);
      DP_EMIT: begin
        mdata_q <= {res_drop_q, res_byte_q, res_valid_q, res_done_q};
        mlast_q <= res_last_q;
      end
      default: ;
    endcase
  end

  assign out_valid_o = mvalid_q;
  assign out_data_o  = mdata_q;
  assign out_last_o  = mlast_q;

endmodule

>>> rtl/slip_receive_ring_deframer.sv
// SLIP receive deframer over a ring store; one request in flight at a time.
// Per request: a line byte is dispatched and emitted, with a read and check of the byte
// before it when an end byte checks it; a read with no frame ready emits at once, else it
// reads a plain byte, or an escape and its code byte. A frame's last byte or a drop then
// releases the frame and searches for the next end up to the write pointer before emitting.
// Reset (rst_ni low, asynchronous) empties the ring and sets max length 1280.
module slip_receive_ring_deframer #(
  parameter int unsigned BufDepth = slrd_pkg::BufDepthDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,  // rx_byte
  input  logic                      s_axis_tuser,  // op
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [15:0]               m_axis_tdata,  // frame_done, out_valid, out_byte,
                                                   // out_dropped, zero fill
  output logic                      m_axis_tlast,  // out_last
  input  logic                      cfg_we_i,
  input  logic [slrd_pkg::CfgW-1:0] cfg_wdata_i
);
  import slrd_pkg::*;

  dp_op_e      op;
  dp_status_t  st;
  logic [10:0] mdata;

  slrd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .st_i        (st),
    .op_o        (op)
  );

  slrd_datapath #(
    .BufDepth (BufDepth)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (op),
    .st_o        (st),
    .in_op_i     (s_axis_tuser),
    .in_byte_i   (s_axis_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (mdata),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {5'b0, mdata};

endmodule
